// File: hw/rtl/keyframe_spline_interpolator_defines.svh
// Assertion macros for the keyframe spline interpolator.
// Each macro expects clk and rst_n in scope.
`ifndef KEYFRAME_SPLINE_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_SPLINE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define KFSI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KFSI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/kfsi_pkg.sv
// ----------------------------------------------------------------------------
// kfsi_pkg
// Shared types, constants and helpers of the keyframe spline interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package kfsi_pkg;

    localparam int MAX_KEYS     = 16;
    localparam int NUM_CHANNELS = 16;
    localparam int KIDX_W       = $clog2(MAX_KEYS);
    localparam int CNT_W        = KIDX_W + 1;
    localparam int CH_W         = 4;
    localparam int ADDR_W       = KIDX_W + CH_W;
    localparam int ACC_W        = 38;
    localparam int U_W          = 17;
    localparam int STEP_W       = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_LOOP   = 2'd0,
        REG_SPLINE = 2'd1,
        REG_EASE   = 2'd2,
        REG_STEP   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        M_SPLINE,
        M_EASE,
        M_STEP,
        M_LIN
    } meth_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_FIND,
        S_INS_SHIFT,
        S_INS_CLR,
        S_REM,
        S_SETV,
        S_EV_LAST,
        S_EV_MOD,
        S_EV_FIRST,
        S_EV_SEG0,
        S_EV_SEG,
        S_EV_FRAC,
        S_EV_DIVF,
        S_EV_ROW,
        S_CH_RD,
        S_CH_COEF,
        S_CH_MST,
        S_CH_MAC,
        S_CH_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    localparam logic        LOOP_RST   = 1'b0;
    localparam logic [15:0] SPLINE_RST = 16'd63;
    localparam logic [15:0] EASE_RST   = 16'd64;
    localparam logic [15:0] STEP_RST   = 16'd32768;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sh7FFFFFFF))
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -ACC_W'(64'sh80000000))
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/keyframe_spline_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_spline_interpolator
// Time-sorted keyframe table with Catmull-Rom, ease, step and linear
// evaluation over all channels.
// ----------------------------------------------------------------------------
// Usage:
//  A request is taken when start is high and busy is low. op selects insert,
//  remove, set value or evaluate. Results appear for one cycle each with
//  result_strobe; last marks the final one. The receiver cannot stall.
//  Insert, remove and set value give one result; evaluate gives one per
//  channel, or one with status empty timeline.
//  Insert runs a lower-bound walk, then a clear of the new row. Evaluate on a
//  non-empty table walks up to 15 segments, runs the bit-serial divider for
//  the wrap and for the fraction, does 4 row lookups, then per channel reads
//  the value memory and makes passes of the shared multiplier: 3 Horner steps
//  for Catmull-Rom and ease, one pass for linear, none for step.
//  busy is low between requests; one request at a time.
//  Reset empties the table and loads the register defaults. Key rows are
//  reached through an index map, so insert and remove move no value data.
//  Configuration writes are taken at any edge with cfg_write high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyframe_spline_interpolator_defines.svh"

module keyframe_spline_interpolator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] key_time,
    input  wire logic               key_mode,
    input  wire logic [3:0]         key_index,
    input  wire logic [3:0]         channel,
    input  wire logic signed [31:0] value,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    result_strobe,
    output logic [3:0]              out_channel,
    output logic signed [31:0]      out_value,
    output logic                    last,
    output logic [1:0]              status,
    output logic [4:0]              position
);
    import kfsi_pkg::*;

    localparam int MEM_DEPTH = MAX_KEYS * NUM_CHANNELS;

    // configuration
    logic        loop_reg;
    logic [15:0] spline_mask_reg, ease_mask_reg, step_mask_reg;

    // table
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [31:0]       times_reg [MAX_KEYS];
    logic signed [31:0]       times_next [MAX_KEYS];
    logic                     modes_reg [MAX_KEYS];
    logic                     modes_next [MAX_KEYS];
    logic [KIDX_W-1:0]        map_reg [MAX_KEYS];
    logic [KIDX_W-1:0]        map_next [MAX_KEYS];
    logic signed [31:0]       vals_mem [MEM_DEPTH];
    logic signed [31:0]       rdata_reg;

    // request and working registers
    logic signed [31:0]       t_reg, t_next;
    logic                     kmode_reg, kmode_next;
    logic [KIDX_W-1:0]        kidx_reg, kidx_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic signed [31:0]       val_reg, val_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [31:0]       tl_reg, tl_next;
    logic signed [31:0]       prev_reg, prev_next;
    logic signed [31:0]       seg_t0_reg, seg_t0_next;
    logic signed [31:0]       seg_t1_reg, seg_t1_next;
    logic [KIDX_W-1:0]        idx_reg, idx_next;
    logic [U_W-1:0]           u_reg, u_next;
    logic                     wrap_reg, wrap_next;
    logic [KIDX_W-1:0]        newrow_reg, newrow_next;
    logic [KIDX_W-1:0]        rows_reg [4];
    logic [KIDX_W-1:0]        rows_next [4];
    logic                     modeidx_reg, modeidx_next;
    logic [CH_W-1:0]          chan_reg, chan_next;
    logic [2:0]               rd_reg, rd_next;
    logic signed [31:0]       p_reg [4];
    logic signed [31:0]       p_next [4];
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  cc_reg, cc_next;
    logic signed [ACC_W-1:0]  cb_reg, cb_next;
    logic signed [ACC_W-1:0]  ca_reg, ca_next;
    logic [1:0]               step_reg, step_next;
    meth_t                    meth_reg, meth_next;

    // result registers
    logic                     strobe_reg;
    logic [CH_W-1:0]          och_reg;
    logic signed [31:0]       oval_reg;
    logic                     olast_reg;
    status_t                  ost_reg;
    logic [CNT_W-1:0]         opos_reg;

    // combinational
    logic                     em, em_last;
    logic [CH_W-1:0]          em_ch;
    logic signed [31:0]       em_val;
    status_t                  em_st;
    logic [CNT_W-1:0]         em_pos;
    logic [KIDX_W-1:0]        t_ridx, m_ridx;
    logic signed [31:0]       t_rd;
    logic [KIDX_W-1:0]        m_rd;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
    logic signed [31:0]       mem_wdata;
    logic [KIDX_W-1:0]        i0, i1p, i3, row_sel;
    logic [CNT_W-1:0]         idx2;
    logic signed [32:0]       span, num;
    logic signed [31:0]       rmod, tc;
    logic signed [ACC_W-1:0]  q0, q1, q2, q3;
    meth_t                    meth_c;

    div_ctl_t                 div_ctl;
    logic [33:0]              div_rem_init, div_rem;
    logic [31:0]              div_dividend, div_quo;
    logic [32:0]              div_divisor;
    logic                     div_done;
    logic                     mac_start, mac_done;
    logic signed [ACC_W-1:0]  mac_res;

    kfsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem),
        .quo      (div_quo)
    );

    kfsi_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .x      (acc_reg),
        .u      (u_reg),
        .y      (cc_reg),
        .done   (mac_done),
        .result (mac_res)
    );

    assign t_rd = times_reg[t_ridx];
    assign m_rd = map_reg[m_ridx];

    // neighbour indices of the segment
    assign i1p  = idx_reg + 1'b1;
    assign idx2 = {1'b0, idx_reg} + CNT_W'(2);
    assign i0   = (idx_reg != '0) ? idx_reg - 1'b1 :
                  (wrap_reg ? KIDX_W'(n_reg - CNT_W'(2)) : '0);
    assign i3   = (idx2 < n_reg) ? idx2[KIDX_W-1:0] :
                  (wrap_reg ? KIDX_W'(1) : KIDX_W'(n_reg - 1'b1));

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    row_sel = i0;
            2'd1:    row_sel = idx_reg;
            2'd2:    row_sel = i1p;
            default: row_sel = i3;
        endcase
    end

    assign span = {seg_t1_reg[31], seg_t1_reg} - {seg_t0_reg[31], seg_t0_reg};
    assign num  = {t_reg[31], t_reg} - {seg_t0_reg[31], seg_t0_reg};
    assign rmod = $signed(div_rem[31:0]);
    assign tc   = (t_reg > tl_reg) ? tl_reg : t_reg;

    // divider operands: fraction in S_EV_FRAC, wrap remainder otherwise
    assign div_rem_init = (state_reg == S_EV_FRAC) ? {1'b0, num} : '0;
    assign div_dividend = (state_reg == S_EV_FRAC) ? '0 :
                          (t_reg[31] ? 32'(-t_reg) : 32'(t_reg));
    assign div_divisor  = (state_reg == S_EV_FRAC) ? span : {1'b0, t_rd};

    // method choice, then endpoints for Catmull-Rom; ease repeats the segment keys
    always_comb
    begin
        meth_c = M_LIN;
        if (n_reg == CNT_W'(1))
        begin
            meth_c = M_STEP;
        end
        else if (modeidx_reg && spline_mask_reg[chan_reg])
        begin
            meth_c = M_SPLINE;
        end
        else if (ease_mask_reg[chan_reg])
        begin
            meth_c = M_EASE;
        end
        else if (step_mask_reg[chan_reg])
        begin
            meth_c = M_STEP;
        end
        q1 = ACC_W'(p_reg[1]);
        q2 = ACC_W'(p_reg[2]);
        if (meth_c == M_SPLINE)
        begin
            q0 = ACC_W'(p_reg[0]);
            q3 = ACC_W'(p_reg[3]);
        end
        else
        begin
            q0 = q1;
            q3 = q2;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        times_next   = times_reg;
        modes_next   = modes_reg;
        map_next     = map_reg;
        t_next       = t_reg;
        kmode_next   = kmode_reg;
        kidx_next    = kidx_reg;
        ch_next      = ch_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        tl_next      = tl_reg;
        prev_next    = prev_reg;
        seg_t0_next  = seg_t0_reg;
        seg_t1_next  = seg_t1_reg;
        idx_next     = idx_reg;
        u_next       = u_reg;
        wrap_next    = wrap_reg;
        newrow_next  = newrow_reg;
        rows_next    = rows_reg;
        modeidx_next = modeidx_reg;
        chan_next    = chan_reg;
        rd_next      = rd_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        cc_next      = cc_reg;
        cb_next      = cb_reg;
        ca_next      = ca_reg;
        step_next    = step_reg;
        meth_next    = meth_reg;
        em           = 1'b0;
        em_last      = 1'b1;
        em_ch        = '0;
        em_val       = '0;
        em_st        = ST_OK;
        em_pos       = n_reg;
        t_ridx       = '0;
        m_ridx       = '0;
        mem_we       = 1'b0;
        mem_waddr    = {newrow_reg, chan_reg};
        mem_wdata    = '0;
        mem_raddr    = {rows_reg[rd_reg[1:0]], chan_reg};
        div_ctl      = '{start: 1'b0, steps: STEP_W'(32)};
        mac_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    t_next     = key_time;
                    kmode_next = key_mode;
                    kidx_next  = KIDX_W'(key_index);
                    ch_next    = channel;
                    val_next   = value;
                    case (op_t'(op))
                        OP_INSERT:
                        begin
                            if (n_reg >= CNT_W'(MAX_KEYS))
                            begin
                                em    = 1'b1;
                                em_st = ST_FULL;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_INS_FIND;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (CNT_W'(key_index) >= n_reg)
                            begin
                                em    = 1'b1;
                                em_st = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_REM;
                            end
                        end
                        OP_SET:
                        begin
                            if (CNT_W'(key_index) >= n_reg
                                || {1'b0, channel} >= 5'(NUM_CHANNELS))
                            begin
                                em    = 1'b1;
                                em_st = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_SETV;
                            end
                        end
                        OP_EVAL:
                        begin
                            state_next = S_EV_LAST;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_FIND:
            begin
                // lower bound: first key not earlier than the new time
                t_ridx = cnt_reg[KIDX_W-1:0];
                if (cnt_reg < n_reg && t_rd < t_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_INS_SHIFT;
                end
            end

            S_INS_SHIFT:
            begin
                m_ridx      = n_reg[KIDX_W-1:0];
                newrow_next = m_rd;
                for (int i = 1; i < MAX_KEYS; i++)
                begin
                    if (CNT_W'(i) > cnt_reg && CNT_W'(i) <= n_reg)
                    begin
                        times_next[i] = times_reg[i-1];
                        modes_next[i] = modes_reg[i-1];
                        map_next[i]   = map_reg[i-1];
                    end
                end
                times_next[cnt_reg[KIDX_W-1:0]] = t_reg;
                modes_next[cnt_reg[KIDX_W-1:0]] = kmode_reg;
                map_next[cnt_reg[KIDX_W-1:0]]   = m_rd;
                n_next     = n_reg + 1'b1;
                chan_next  = '0;
                state_next = S_INS_CLR;
            end

            S_INS_CLR:
            begin
                mem_we    = 1'b1;
                chan_next = chan_reg + 1'b1;
                if (chan_reg == CH_W'(NUM_CHANNELS - 1))
                begin
                    em         = 1'b1;
                    em_pos     = cnt_reg;
                    state_next = S_IDLE;
                end
            end

            S_REM:
            begin
                m_ridx = kidx_reg;
                for (int i = 0; i < MAX_KEYS - 1; i++)
                begin
                    if (CNT_W'(i) >= CNT_W'(kidx_reg) && CNT_W'(i) < n_reg - 1'b1)
                    begin
                        times_next[i] = times_reg[i+1];
                        modes_next[i] = modes_reg[i+1];
                        map_next[i]   = map_reg[i+1];
                    end
                end
                // freed row parks just past the end of the table
                map_next[KIDX_W'(n_reg - 1'b1)] = m_rd;
                n_next     = n_reg - 1'b1;
                em         = 1'b1;
                em_pos     = n_reg - 1'b1;
                state_next = S_IDLE;
            end

            S_SETV:
            begin
                m_ridx     = kidx_reg;
                mem_we     = 1'b1;
                mem_waddr  = {m_rd, ch_reg};
                mem_wdata  = val_reg;
                em         = 1'b1;
                state_next = S_IDLE;
            end

            S_EV_LAST:
            begin
                t_ridx    = KIDX_W'(n_reg - 1'b1);
                tl_next   = t_rd;
                wrap_next = loop_reg && (n_reg >= CNT_W'(3));
                idx_next  = '0;
                u_next    = '0;
                cnt_next  = '0;
                if (n_reg == '0)
                begin
                    em         = 1'b1;
                    em_st      = ST_EMPTY;
                    em_pos     = '0;
                    state_next = S_IDLE;
                end
                else if (n_reg == CNT_W'(1))
                begin
                    state_next = S_EV_ROW;
                end
                else if (loop_reg && n_reg >= CNT_W'(3))
                begin
                    if (t_rd > 0)
                    begin
                        div_ctl.start = 1'b1;
                        state_next    = S_EV_MOD;
                    end
                    else
                    begin
                        state_next = S_EV_SEG0;
                    end
                end
                else
                begin
                    state_next = S_EV_FIRST;
                end
            end

            S_EV_MOD:
            begin
                if (div_done)
                begin
                    // floor modulo: fold a negative remainder back into range
                    t_next     = (t_reg[31] && rmod != 0) ? tl_reg - rmod : rmod;
                    state_next = S_EV_SEG0;
                end
            end

            S_EV_FIRST:
            begin
                t_ridx     = '0;
                t_next     = (tc < t_rd) ? t_rd : tc;
                state_next = S_EV_SEG0;
            end

            S_EV_SEG0:
            begin
                t_ridx      = '0;
                prev_next   = t_rd;
                seg_t0_next = t_rd;
                cnt_next    = '0;
                state_next  = S_EV_SEG;
            end

            S_EV_SEG:
            begin
                t_ridx = KIDX_W'(cnt_reg + 1'b1);
                if (cnt_reg == '0)
                begin
                    seg_t1_next = t_rd;
                end
                if (prev_reg <= t_reg && t_reg <= t_rd)
                begin
                    idx_next    = cnt_reg[KIDX_W-1:0];
                    seg_t0_next = prev_reg;
                    seg_t1_next = t_rd;
                    state_next  = S_EV_FRAC;
                end
                else if (cnt_reg + CNT_W'(2) >= n_reg)
                begin
                    state_next = S_EV_FRAC;
                end
                else
                begin
                    prev_next = t_rd;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end

            S_EV_FRAC:
            begin
                cnt_next   = '0;
                state_next = S_EV_ROW;
                if (span <= 0 || num <= 0)
                begin
                    u_next = '0;
                end
                else if (num >= span)
                begin
                    u_next = U_W'(65536);
                end
                else
                begin
                    div_ctl    = '{start: 1'b1, steps: STEP_W'(16)};
                    state_next = S_EV_DIVF;
                end
            end

            S_EV_DIVF:
            begin
                if (div_done)
                begin
                    u_next     = {1'b0, div_quo[15:0]};
                    state_next = S_EV_ROW;
                end
            end

            S_EV_ROW:
            begin
                m_ridx                = row_sel;
                rows_next[cnt_reg[1:0]] = m_rd;
                if (cnt_reg == '0)
                begin
                    modeidx_next = modes_reg[idx_reg];
                end
                if (cnt_reg == CNT_W'(3))
                begin
                    chan_next  = '0;
                    rd_next    = '0;
                    state_next = S_CH_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_CH_RD:
            begin
                // read data arrives in the cycle after its address
                if (rd_reg != '0)
                begin
                    p_next[2'(rd_reg - 1'b1)] = rdata_reg;
                end
                if (rd_reg == 3'd4)
                begin
                    state_next = S_CH_COEF;
                end
                else
                begin
                    rd_next = rd_reg + 1'b1;
                end
            end

            S_CH_COEF:
            begin
                meth_next = meth_c;
                if (meth_c == M_STEP)
                begin
                    state_next = S_CH_OUT;
                end
                else if (meth_c == M_LIN)
                begin
                    acc_next   = q2 - q1;
                    cc_next    = q1;
                    step_next  = 2'd1;
                    state_next = S_CH_MST;
                end
                else
                begin
                    acc_next   = -q0 + 3 * q1 - 3 * q2 + q3;
                    cc_next    = 2 * q0 - 5 * q1 + 4 * q2 - q3;
                    cb_next    = q2 - q0;
                    ca_next    = 2 * q1;
                    step_next  = 2'd3;
                    state_next = S_CH_MST;
                end
            end

            S_CH_MST:
            begin
                mac_start  = 1'b1;
                state_next = S_CH_MAC;
            end

            S_CH_MAC:
            begin
                if (mac_done)
                begin
                    acc_next = mac_res;
                    cc_next  = cb_reg;
                    cb_next  = ca_reg;
                    if (step_reg == 2'd1)
                    begin
                        state_next = S_CH_OUT;
                    end
                    else
                    begin
                        step_next  = step_reg - 1'b1;
                        state_next = S_CH_MST;
                    end
                end
            end

            S_CH_OUT:
            begin
                em      = 1'b1;
                em_ch   = chan_reg;
                em_last = (chan_reg == CH_W'(NUM_CHANNELS - 1));
                case (meth_reg)
                    M_SPLINE: em_val = sat32(acc_reg >>> 1);
                    M_EASE:   em_val = sat32(acc_reg >>> 1);
                    M_LIN:    em_val = sat32(acc_reg);
                    default:  em_val = (u_reg < U_W'(32768)) ? p_reg[1] : p_reg[2];
                endcase
                if (em_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    chan_next  = chan_reg + 1'b1;
                    rd_next    = '0;
                    state_next = S_CH_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < MAX_KEYS; i++)
            begin
                map_reg[i] <= KIDX_W'(i);
            end
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            strobe_reg <= em;
            map_reg    <= map_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_reg        <= LOOP_RST;
            spline_mask_reg <= SPLINE_RST;
            ease_mask_reg   <= EASE_RST;
            step_mask_reg   <= STEP_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LOOP:   loop_reg        <= cfg_data[0];
                REG_SPLINE: spline_mask_reg <= cfg_data;
                REG_EASE:   ease_mask_reg   <= cfg_data;
                REG_STEP:   step_mask_reg   <= cfg_data;
                default:    loop_reg        <= loop_reg;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        times_reg   <= times_next;
        modes_reg   <= modes_next;
        t_reg       <= t_next;
        kmode_reg   <= kmode_next;
        kidx_reg    <= kidx_next;
        ch_reg      <= ch_next;
        val_reg     <= val_next;
        cnt_reg     <= cnt_next;
        tl_reg      <= tl_next;
        prev_reg    <= prev_next;
        seg_t0_reg  <= seg_t0_next;
        seg_t1_reg  <= seg_t1_next;
        idx_reg     <= idx_next;
        u_reg       <= u_next;
        wrap_reg    <= wrap_next;
        newrow_reg  <= newrow_next;
        rows_reg    <= rows_next;
        modeidx_reg <= modeidx_next;
        chan_reg    <= chan_next;
        rd_reg      <= rd_next;
        p_reg       <= p_next;
        acc_reg     <= acc_next;
        cc_reg      <= cc_next;
        cb_reg      <= cb_next;
        ca_reg      <= ca_next;
        step_reg    <= step_next;
        meth_reg    <= meth_next;
        och_reg     <= em_ch;
        oval_reg    <= em_val;
        olast_reg   <= em_last;
        ost_reg     <= em_st;
        opos_reg    <= em_pos;
    end

    // channel value memory, rows reached through map_reg
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vals_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= vals_mem[mem_raddr];
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign out_channel   = och_reg;
    assign out_value     = oval_reg;
    assign last          = olast_reg;
    assign status        = ost_reg;
    assign position      = opos_reg;

    `KFSI_ASSERT_IMP(a_mid_result_busy, result_strobe && !last, busy,
        "non-final result while sequencer idle")
    `KFSI_ASSERT_IMP(a_div_done_wait, div_done,
        state_reg == S_EV_MOD || state_reg == S_EV_DIVF,
        "divider finished outside a wait state")
    `KFSI_ASSERT_NXT(a_div_start_wait, div_ctl.start,
        state_reg == S_EV_MOD || state_reg == S_EV_DIVF,
        "divider started without waiting for it")
    `KFSI_ASSERT_IMP(a_empty_single, result_strobe && status == ST_EMPTY,
        last && out_value == 0 && position == 0,
        "empty timeline result malformed")
    `KFSI_ASSERT_IMP(a_count_range, 1'b1, n_reg <= CNT_W'(MAX_KEYS),
        "key count beyond table size")

endmodule

`default_nettype wire

// File: hw/rtl/kfsi_div.sv
// ----------------------------------------------------------------------------
// kfsi_div
// Restoring divider, one quotient bit per cycle. Used for the time wrap
// remainder and for the segment fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module kfsi_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kfsi_pkg::div_ctl_t   ctl,
    input  wire logic [33:0]          rem_init,
    input  wire logic [31:0]          dividend,
    input  wire logic [32:0]          divisor,
    output logic                      done,
    output logic [33:0]               rem,
    output logic [31:0]               quo
);
    import kfsi_pkg::*;

    logic [33:0]       rem_reg, rem_next;
    logic [31:0]       sh_reg, sh_next;
    logic [31:0]       quo_reg, quo_next;
    logic [32:0]       dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [33:0]       trial;
    logic              ge;

    assign trial = {rem_reg[32:0], sh_reg[31]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next = rem_init;
            sh_next  = dividend;
            quo_next = '0;
            dvs_next = divisor;
            cnt_next = ctl.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? trial - {1'b0, dvs_reg} : trial;
            sh_next   = {sh_reg[30:0], 1'b0};
            quo_next  = {quo_reg[30:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: hw/rtl/kfsi_mac.sv
// ----------------------------------------------------------------------------
// kfsi_mac
// Shared multiply-add: result = floor(x * u / 65536) + y, product and sum registered in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module kfsi_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [kfsi_pkg::ACC_W-1:0]     x,
    input  wire logic [kfsi_pkg::U_W-1:0]              u,
    input  wire logic signed [kfsi_pkg::ACC_W-1:0]     y,
    output logic                                       done,
    output logic signed [kfsi_pkg::ACC_W-1:0]          result
);
    import kfsi_pkg::*;

    localparam int PROD_W = ACC_W + U_W + 1;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  res_reg, res_next;
    logic                     v1_reg, v1_next;
    logic                     done_reg, done_next;
    logic signed [U_W:0]      u_s;

    assign u_s = $signed({1'b0, u});

    always_comb
    begin
        prod_next = prod_reg;
        res_next  = res_reg;
        v1_next   = start;
        done_next = v1_reg;
        if (start)
        begin
            prod_next = x * u_s;
        end
        if (v1_reg)
        begin
            // arithmetic shift gives the floor
            res_next = ACC_W'(prod_reg >>> 16) + y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe spline interpolator: random and
// directed key-table requests, predicted per channel and compared on strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kfsi_pkg::*;

    typedef struct packed {
        logic [3:0]         ch;
        logic signed [31:0] val;
        logic               lst;
        logic [1:0]         st;
        logic [4:0]         pos;
    } res_t;

    class interp_scoreboard;
        // predictor state
        logic               loop_en;
        logic [15:0]        spl_m, ease_m, step_m;
        int                 nkeys;
        longint             ktime [MAX_KEYS];
        bit                 kmode [MAX_KEYS];
        longint             kval  [MAX_KEYS][NUM_CHANNELS];
        res_t               pending [$];
        int                 errors;

        function void reset_state();
            loop_en = LOOP_RST;
            spl_m = SPLINE_RST;
            ease_m = EASE_RST;
            step_m = STEP_RST;
            nkeys = 0;
            errors = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [15:0] d);
            case (idx)
                REG_LOOP:   loop_en = d[0];
                REG_SPLINE: spl_m = d;
                REG_EASE:   ease_m = d;
                default:    step_m = d;
            endcase
        endfunction

        function longint fdiv16(longint x);
            return x >>> 16;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sh7FFFFFFF)
                return 64'sh7FFFFFFF;
            if (v < -64'sh80000000)
                return -64'sh80000000;
            return v;
        endfunction

        function longint catmull(longint p0, longint p1, longint p2, longint p3, longint u);
            longint acc;
            acc = fdiv16((-p0 + 3*p1 - 3*p2 + p3) * u) + (2*p0 - 5*p1 + 4*p2 - p3);
            acc = fdiv16(acc * u) + (p2 - p0);
            acc = fdiv16(acc * u) + 2*p1;
            return acc >>> 1;
        endfunction

        function void push(logic [3:0] ch, longint v, bit l, status_t s, int p);
            res_t r;
            r.ch = ch;
            r.val = v[31:0];
            r.lst = l;
            r.st = s;
            r.pos = p[4:0];
            pending.push_back(r);
        endfunction

        function void note_request(op_t o, logic signed [31:0] kt, logic km,
                                   logic [3:0] ki, logic [3:0] ch, logic signed [31:0] v);
            int p, seg, i0, i3;
            longint t, per, span, u, r, v0, v1;
            bit wrap;
            case (o)
                OP_INSERT:
                begin
                    if (nkeys >= MAX_KEYS)
                    begin
                        push(0, 0, 1, ST_FULL, nkeys);
                        return;
                    end
                    p = 0;
                    while (p < nkeys && ktime[p] < kt)
                        p++;
                    for (int i = nkeys; i > p; i--)
                    begin
                        ktime[i] = ktime[i-1];
                        kmode[i] = kmode[i-1];
                        kval[i] = kval[i-1];
                    end
                    ktime[p] = kt;
                    kmode[p] = km;
                    for (int j = 0; j < NUM_CHANNELS; j++)
                        kval[p][j] = 0;
                    nkeys++;
                    push(0, 0, 1, ST_OK, p);
                end
                OP_REMOVE:
                begin
                    if (ki >= nkeys)
                    begin
                        push(0, 0, 1, ST_BAD_INDEX, nkeys);
                        return;
                    end
                    for (int i = ki; i + 1 < nkeys; i++)
                    begin
                        ktime[i] = ktime[i+1];
                        kmode[i] = kmode[i+1];
                        kval[i] = kval[i+1];
                    end
                    nkeys--;
                    push(0, 0, 1, ST_OK, nkeys);
                end
                OP_SET:
                begin
                    if (ki >= nkeys)
                    begin
                        push(0, 0, 1, ST_BAD_INDEX, nkeys);
                        return;
                    end
                    kval[ki][ch] = v;
                    push(0, 0, 1, ST_OK, nkeys);
                end
                default:
                begin
                    if (nkeys == 0)
                    begin
                        push(0, 0, 1, ST_EMPTY, 0);
                        return;
                    end
                    if (nkeys == 1)
                    begin
                        for (int j = 0; j < NUM_CHANNELS; j++)
                            push(j, kval[0][j], j == NUM_CHANNELS-1, ST_OK, 1);
                        return;
                    end
                    t = kt;
                    wrap = loop_en && nkeys >= 3;
                    if (wrap)
                    begin
                        per = ktime[nkeys-1];
                        if (per > 0)
                        begin
                            t = t % per;
                            if (t < 0)
                                t += per;
                        end
                    end
                    else
                    begin
                        if (t > ktime[nkeys-1])
                            t = ktime[nkeys-1];
                        if (t < ktime[0])
                            t = ktime[0];
                    end
                    seg = 0;
                    for (int i = 0; i + 1 < nkeys; i++)
                        if (t >= ktime[i] && t <= ktime[i+1])
                        begin
                            seg = i;
                            break;
                        end
                    span = ktime[seg+1] - ktime[seg];
                    u = 0;
                    if (span > 0)
                    begin
                        r = t - ktime[seg];
                        if (r < 0)
                            r = 0;
                        u = (r * 65536) / span;
                        if (u > 65536)
                            u = 65536;
                    end
                    if (wrap)
                    begin
                        i0 = seg > 0 ? seg - 1 : nkeys - 2;
                        i3 = seg + 2 < nkeys ? seg + 2 : 1 + (seg + 2 - nkeys);
                    end
                    else
                    begin
                        i0 = seg > 0 ? seg - 1 : 0;
                        i3 = seg + 2 < nkeys ? seg + 2 : nkeys - 1;
                    end
                    for (int j = 0; j < NUM_CHANNELS; j++)
                    begin
                        v0 = kval[seg][j];
                        v1 = kval[seg+1][j];
                        if (kmode[seg] && spl_m[j])
                            r = catmull(kval[i0][j], v0, v1, kval[i3][j], u);
                        else if (ease_m[j])
                            r = catmull(v0, v0, v1, v1, u);
                        else if (step_m[j])
                            r = u < 32768 ? v0 : v1;
                        else
                            r = v0 + fdiv16((v1 - v0) * u);
                        push(j, clip32(r), j == NUM_CHANNELS-1, ST_OK, nkeys);
                    end
                end
            endcase
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result ch=%0d val=%0d", got.ch, got.val);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.ch !== want.ch)
            begin
                $error("out_channel exp %0d got %0d", want.ch, got.ch);
                errors++;
            end
            if (got.val !== want.val)
            begin
                $error("out_value exp %0d got %0d", want.val, got.val);
                errors++;
            end
            if (got.lst !== want.lst)
            begin
                $error("last exp %0d got %0d", want.lst, got.lst);
                errors++;
            end
            if (got.st !== want.st)
            begin
                $error("status exp %0d got %0d", want.st, got.st);
                errors++;
            end
            if (got.pos !== want.pos)
            begin
                $error("position exp %0d got %0d", want.pos, got.pos);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         op = OP_INSERT;
    logic signed [31:0] key_time = '0;
    logic               key_mode = 1'b0;
    logic [3:0]         key_index = '0;
    logic [3:0]         channel = '0;
    logic signed [31:0] value = '0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = REG_LOOP;
    logic [15:0]        cfg_data = '0;
    logic               result_strobe;
    logic [3:0]         out_channel;
    logic signed [31:0] out_value;
    logic               last;
    logic [1:0]         status;
    logic [4:0]         position;

    interp_scoreboard   board;
    longint             cycle_count = 0;
    bit                 calm;
    int                 key_slots;

    localparam longint CYCLE_LIMIT = 2000000;

    always #6 clk = ~clk;

    keyframe_spline_interpolator dut (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("keyframe_spline_interpolator test failed");
            $finish;
        end
        if (rst_n && result_strobe)
            board.check_result({out_channel, out_value, last, status, position});
    end

    task automatic request(op_t o, logic signed [31:0] kt, logic km,
                           logic [3:0] ki, logic [3:0] ch, logic signed [31:0] v);
        while (!calm && $urandom_range(99) < 12)
            @(posedge clk);
        start <= 1'b1;
        op <= o;
        key_time <= kt;
        key_mode <= km;
        key_index <= ki;
        channel <= ch;
        value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(o, kt, km, ki, ch, v);
        start <= 1'b0;
        // wait for the request to finish before the next one is framed
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] d);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(idx, d);
    endtask

    function automatic logic signed [31:0] rand_time();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(20 << 16));
            2:       return -$signed($urandom_range(4 << 16));
            default: return $signed($urandom_range(4)) << 16;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic random_request();
        int k;
        k = $urandom_range(99);
        key_slots = board.nkeys;
        if (k < 22)
            request(OP_INSERT, rand_time(), $urandom_range(1), $urandom, $urandom, $urandom);
        else if (k < 32)
            request(OP_REMOVE, $urandom, $urandom, key_slots > 0 && $urandom_range(3) != 0
                    ? $urandom_range(key_slots - 1) : $urandom, $urandom, $urandom);
        else if (k < 62)
            request(OP_SET, $urandom, $urandom, key_slots > 0 && $urandom_range(7) != 0
                    ? $urandom_range(key_slots - 1) : $urandom, $urandom, rand_value());
        else
            request(OP_EVAL, rand_time(), $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        board = new();
        board.reset_state();
        calm = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty timeline, bad indexes, single key, equal times, full table
        request(OP_EVAL, 0, 0, 0, 0, 0);
        request(OP_REMOVE, 0, 0, 0, 0, 0);
        request(OP_SET, 0, 0, 4'hF, 4'hF, 32'sh7FFFFFFF);
        request(OP_INSERT, 32'sh0002_0000, 1, 0, 0, 0);
        request(OP_SET, 0, 0, 0, 4'hF, 32'sh80000000);
        request(OP_SET, 0, 0, 0, 0, 32'sh7FFFFFFF);
        request(OP_EVAL, 32'sh80000000, 0, 0, 0, 0);
        request(OP_INSERT, 32'sh0002_0000, 0, 0, 0, 0);
        request(OP_INSERT, 32'sh7FFFFFFF, 1, 0, 0, 0);
        request(OP_INSERT, 32'sh80000000, 1, 0, 0, 0);
        request(OP_SET, 0, 0, 3, 0, 32'sh80000000);
        request(OP_SET, 0, 0, 1, 6, 32'sh7FFFFFFF);
        request(OP_EVAL, 32'sh0002_0000, 0, 0, 0, 0);
        request(OP_EVAL, 32'sh7FFFFFFF, 0, 0, 0, 0);
        for (int i = 0; i < 13; i++)
            request(OP_INSERT, i << 15, i[0], 0, 0, 0);
        request(OP_INSERT, 0, 0, 0, 0, 0);
        request(OP_REMOVE, 0, 0, 4'hF, 0, 0);
        request(OP_REMOVE, 0, 0, 0, 0, 0);

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_LOOP, 16'h0001);
                    write_reg(REG_SPLINE, 16'hFFFF);
                end
                1:
                begin
                    write_reg(REG_SPLINE, 16'h0000);
                    write_reg(REG_EASE, 16'h00FF);
                    write_reg(REG_STEP, 16'hFFFF);
                end
                2:
                begin
                    write_reg(REG_LOOP, 16'h0000);
                    write_reg(REG_EASE, 16'h0000);
                    write_reg(REG_STEP, 16'h0000);
                end
                3:
                begin
                    write_reg(REG_LOOP, 16'hFFFF);
                    write_reg(REG_SPLINE, $urandom);
                    write_reg(REG_EASE, $urandom);
                    write_reg(REG_STEP, $urandom);
                end
                4:
                begin
                    write_reg(REG_LOOP, 16'h0000);
                    write_reg(REG_SPLINE, 16'hFFFF);
                    write_reg(REG_EASE, 16'hFFFF);
                end
                default:
                begin
                    write_reg(REG_LOOP, 16'h0001);
                    write_reg(REG_SPLINE, 16'h003F);
                end
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 42; n++)
                random_request();
        end
        calm = 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("keyframe_spline_interpolator test passed");
        else
            $display("keyframe_spline_interpolator test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/kfsi_pkg.sv
hw/rtl/kfsi_div.sv
hw/rtl/kfsi_mac.sv
hw/rtl/keyframe_spline_interpolator.sv
tb/sv/tb.sv
